// File: design/chacha20_block_function_assert.svh
// ----------------------------------------------------------------------------
// ChaCha20 block function assertion macros
// Assertion wrappers shared by the RTL; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_BLOCK_FUNCTION_ASSERT_SVH
`define CHACHA20_BLOCK_FUNCTION_ASSERT_SVH

`ifndef SYNTHESIS
`define CC20_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chacha20 assertion failed");
`define CC20_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chacha20 assertion failed");
`else
`define CC20_ASSERT_IMPL(name, ante, cons)
`define CC20_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: design/cc20_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 package
// Word, index and lane types and the quarter-round step codes.
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam int WORD_W  = 32;
    localparam int FIELD_W = 64;
    localparam int WORDS   = 16;
    localparam int LANES   = 4;
    localparam int IDX_W   = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [1:0]        step_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    // Steps of one quarter-round, in order.
    localparam step_t STEP_AD_16 = 2'd0;
    localparam step_t STEP_CB_12 = 2'd1;
    localparam step_t STEP_AD_8  = 2'd2;
    localparam step_t STEP_CB_7  = 2'd3;

    localparam idx_t LAST_WORD_IDX = 4'd15;

endpackage

// File: design/cc20_if.sv
// ----------------------------------------------------------------------------
// ChaCha20 channel interfaces
// Valid/ready channels for the input state and the output words.
// ----------------------------------------------------------------------------
interface cc20_in_if;
    logic                         valid;
    logic                         ready;
    logic [cc20_pkg::FIELD_W-1:0] state_words_0_1;
    logic [cc20_pkg::FIELD_W-1:0] state_words_2_3;
    logic [cc20_pkg::FIELD_W-1:0] state_words_4_5;
    logic [cc20_pkg::FIELD_W-1:0] state_words_6_7;
    logic [cc20_pkg::FIELD_W-1:0] state_words_8_9;
    logic [cc20_pkg::FIELD_W-1:0] state_words_10_11;
    logic [cc20_pkg::FIELD_W-1:0] state_words_12_13;
    logic [cc20_pkg::FIELD_W-1:0] state_words_14_15;

    modport source (
        output valid, state_words_0_1, state_words_2_3, state_words_4_5,
               state_words_6_7, state_words_8_9, state_words_10_11,
               state_words_12_13, state_words_14_15,
        input  ready
    );
    modport sink (
        input  valid, state_words_0_1, state_words_2_3, state_words_4_5,
               state_words_6_7, state_words_8_9, state_words_10_11,
               state_words_12_13, state_words_14_15,
        output ready
    );
endinterface

interface cc20_out_if;
    logic                  valid;
    logic                  ready;
    cc20_pkg::idx_t        word_index;
    cc20_pkg::word_t       keystream_word;
    cc20_pkg::word_t       mixed_word;
    logic                  last_word;

    modport source (
        output valid, word_index, keystream_word, mixed_word, last_word,
        input  ready
    );
    modport sink (
        input  valid, word_index, keystream_word, mixed_word, last_word,
        output ready
    );
endinterface

// File: design/cc20_qr_lane.sv
// ----------------------------------------------------------------------------
// ChaCha20 quarter-round lane
// Performs one add, xor and rotate step of a quarter-round on four words.
// ----------------------------------------------------------------------------
module cc20_qr_lane (
    input  cc20_pkg::step_t step,
    input  cc20_pkg::quad_t quad_in,
    output cc20_pkg::quad_t quad_out
);

    cc20_pkg::word_t sum;
    cc20_pkg::word_t mixed;

    always_comb
    begin
        quad_out = quad_in;
        sum      = '0;
        mixed    = '0;
        unique case (step)
            cc20_pkg::STEP_AD_16:
            begin
                sum        = quad_in.a + quad_in.b;
                mixed      = quad_in.d ^ sum;
                quad_out.a = sum;
                quad_out.d = {mixed[15:0], mixed[31:16]};
            end
            cc20_pkg::STEP_CB_12:
            begin
                sum        = quad_in.c + quad_in.d;
                mixed      = quad_in.b ^ sum;
                quad_out.c = sum;
                quad_out.b = {mixed[19:0], mixed[31:20]};
            end
            cc20_pkg::STEP_AD_8:
            begin
                sum        = quad_in.a + quad_in.b;
                mixed      = quad_in.d ^ sum;
                quad_out.a = sum;
                quad_out.d = {mixed[23:0], mixed[31:24]};
            end
            cc20_pkg::STEP_CB_7:
            begin
                sum        = quad_in.c + quad_in.d;
                mixed      = quad_in.b ^ sum;
                quad_out.c = sum;
                quad_out.b = {mixed[24:0], mixed[31:25]};
            end
            default:
            begin
                quad_out = quad_in;
            end
        endcase
    end

endmodule

// File: design/chacha20_block_function.sv
// ----------------------------------------------------------------------------
// ChaCha20 block function
// Takes a 16-word ChaCha state, runs the rounds and emits the 16 result words.
// ----------------------------------------------------------------------------
// One item is the full input state. After it is accepted the block runs
// ROUND_COUNT rounds: the four quarter-round lanes share one add, xor and
// rotate step per cycle, so a quarter-round takes four steps. It then
// presents the sixteen words in order, one per cycle while the sink is
// ready, and accepts the next item in the cycle after word 15 is taken.
module chacha20_block_function #(
    parameter int ROUND_COUNT = 20
) (
    input  logic           clk,
    input  logic           rst_n,
    cc20_in_if.sink        block_in,
    cc20_out_if.source     word_out
);

`include "chacha20_block_function_assert.svh"

    localparam int ROUND_W = $clog2(ROUND_COUNT);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [ROUND_W-1:0]   round_reg;
    logic [ROUND_W-1:0]   round_next;
    cc20_pkg::step_t      step_reg;
    cc20_pkg::step_t      step_next;
    cc20_pkg::idx_t       word_reg;
    cc20_pkg::idx_t       word_next;

    cc20_pkg::word_t      mix_reg  [cc20_pkg::WORDS];
    cc20_pkg::word_t      mix_next [cc20_pkg::WORDS];
    cc20_pkg::word_t      init_reg [cc20_pkg::WORDS];
    cc20_pkg::word_t      in_words [cc20_pkg::WORDS];
    cc20_pkg::word_t      stepped  [cc20_pkg::WORDS];
    cc20_pkg::word_t      rot_fwd  [cc20_pkg::WORDS];
    cc20_pkg::word_t      rot_bwd  [cc20_pkg::WORDS];

    logic                 accept;
    logic                 last_step;

    assign in_words[0]  = block_in.state_words_0_1[31:0];
    assign in_words[1]  = block_in.state_words_0_1[63:32];
    assign in_words[2]  = block_in.state_words_2_3[31:0];
    assign in_words[3]  = block_in.state_words_2_3[63:32];
    assign in_words[4]  = block_in.state_words_4_5[31:0];
    assign in_words[5]  = block_in.state_words_4_5[63:32];
    assign in_words[6]  = block_in.state_words_6_7[31:0];
    assign in_words[7]  = block_in.state_words_6_7[63:32];
    assign in_words[8]  = block_in.state_words_8_9[31:0];
    assign in_words[9]  = block_in.state_words_8_9[63:32];
    assign in_words[10] = block_in.state_words_10_11[31:0];
    assign in_words[11] = block_in.state_words_10_11[63:32];
    assign in_words[12] = block_in.state_words_12_13[31:0];
    assign in_words[13] = block_in.state_words_12_13[63:32];
    assign in_words[14] = block_in.state_words_14_15[31:0];
    assign in_words[15] = block_in.state_words_14_15[63:32];

    assign block_in.ready = (state_reg == ST_IDLE);
    assign accept         = block_in.valid && block_in.ready;
    assign last_step      = (step_reg == cc20_pkg::STEP_CB_7);

    // Each lane always works on one column. Diagonal rounds are made into
    // column rounds by rotating rows b, c and d left by one, two and three
    // words on the way in and back again on the way out.
    for (genvar lane = 0; lane < cc20_pkg::LANES; lane++)
    begin : g_lane
        cc20_pkg::quad_t quad_in;
        cc20_pkg::quad_t quad_out;

        assign quad_in.a = mix_reg[lane];
        assign quad_in.b = mix_reg[lane + 4];
        assign quad_in.c = mix_reg[lane + 8];
        assign quad_in.d = mix_reg[lane + 12];

        cc20_qr_lane u_lane (
            .step     (step_reg),
            .quad_in  (quad_in),
            .quad_out (quad_out)
        );

        assign stepped[lane]      = quad_out.a;
        assign stepped[lane + 4]  = quad_out.b;
        assign stepped[lane + 8]  = quad_out.c;
        assign stepped[lane + 12] = quad_out.d;
    end

    always_comb
    begin
        for (int w = 0; w < cc20_pkg::WORDS; w++)
        begin
            rot_fwd[w] = stepped[(w & 12) + (((w & 3) + (w >> 2)) & 3)];
            rot_bwd[w] = stepped[(w & 12) + (((w & 3) - (w >> 2) + 4) & 3)];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        step_next  = step_reg;
        word_next  = word_reg;
        mix_next   = mix_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mix_next   = in_words;
                    round_next = '0;
                    step_next  = cc20_pkg::STEP_AD_16;
                    word_next  = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                step_next = step_reg + cc20_pkg::step_t'(1);
                if (!last_step)
                begin
                    mix_next = stepped;
                end
                else if (round_reg[0])
                begin
                    mix_next = rot_bwd;
                end
                else if (round_reg != LAST_ROUND)
                begin
                    mix_next = rot_fwd;
                end
                else
                begin
                    mix_next = stepped;
                end
                if (last_step)
                begin
                    round_next = round_reg + ROUND_W'(1);
                    if (round_reg == LAST_ROUND)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (word_out.ready)
                begin
                    word_next = word_reg + cc20_pkg::idx_t'(1);
                    if (word_reg == cc20_pkg::LAST_WORD_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            step_reg  <= cc20_pkg::STEP_AD_16;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            step_reg  <= step_next;
            word_reg  <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_next;
        if (accept)
        begin
            init_reg <= in_words;
        end
    end

    assign word_out.valid          = (state_reg == ST_EMIT);
    assign word_out.word_index     = word_reg;
    assign word_out.mixed_word     = mix_reg[word_reg];
    assign word_out.keystream_word = mix_reg[word_reg] + init_reg[word_reg];
    assign word_out.last_word      = (word_reg == cc20_pkg::LAST_WORD_IDX);

    `CC20_ASSERT_IMPL(a_no_overlap, word_out.valid, !block_in.ready)
    `CC20_ASSERT_NEXT(a_start, accept, state_reg == ST_ROUND && round_reg == '0 && step_reg == cc20_pkg::STEP_AD_16)
    `CC20_ASSERT_NEXT(a_done, word_out.valid && word_out.ready && word_out.last_word, block_in.ready)
    `CC20_ASSERT_IMPL(a_word_hold, state_reg == ST_ROUND, word_reg == '0)

endmodule

// File: tb/tb_chacha20_block_function.sv
// ----------------------------------------------------------------------------
// ChaCha20 block function testbench
// Drives full sixteen-word input states into the block and checks every
// output word against a cycle-free model of the ChaCha rounds. The model
// computes the mixed word and the keystream word for each position. Stimulus
// is a directed set of corner states followed by random states. The sender
// works in bursts and the receiver stalls on its own pattern, and one long
// receiver hold-off lets the block fill up and stall its input.
// ----------------------------------------------------------------------------
module tb_chacha20_block_function #(
    parameter int ROUNDS = 20
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 292;
    localparam int DIRECTED_ITEMS = 18;
    localparam int HOLD_AFTER_BLOCKS = 40;
    localparam int HOLD_CYCLES = 1500;
    localparam int CYCLE_LIMIT = 800000;

    typedef logic [7:0][cc20_pkg::FIELD_W-1:0] state_fields_t;

    typedef struct packed {
        cc20_pkg::idx_t  word_index;
        cc20_pkg::word_t keystream_word;
        cc20_pkg::word_t mixed_word;
        logic            last_word;
    } key_word_t;

    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_SHUT, RX_HOLD} rx_mode_t;

    class keystream_scoreboard;
        key_word_t expected_words[$];
        int        rounds;
        int        errors;

        function new(int round_count);
            rounds = round_count;
            errors = 0;
        endfunction

        static function cc20_pkg::word_t rotl(cc20_pkg::word_t v, int n);
            return (v << n) | (v >> (cc20_pkg::WORD_W - n));
        endfunction

        static function cc20_pkg::quad_t quarter_round(cc20_pkg::quad_t q);
            q.a = q.a + q.b; q.d = rotl(q.d ^ q.a, 16);
            q.c = q.c + q.d; q.b = rotl(q.b ^ q.c, 12);
            q.a = q.a + q.b; q.d = rotl(q.d ^ q.a, 8);
            q.c = q.c + q.d; q.b = rotl(q.b ^ q.c, 7);
            return q;
        endfunction

        function void note_block(state_fields_t st);
            cc20_pkg::word_t init_w[cc20_pkg::WORDS];
            cc20_pkg::word_t mix_w[cc20_pkg::WORDS];
            cc20_pkg::quad_t q;
            key_word_t       kw;
            int              ia, ib, ic, id;

            for (int i = 0; i < cc20_pkg::WORDS / 2; i++)
            begin
                init_w[2*i]   = st[i][cc20_pkg::WORD_W-1:0];
                init_w[2*i+1] = st[i][cc20_pkg::FIELD_W-1:cc20_pkg::WORD_W];
            end
            mix_w = init_w;
            for (int rd = 0; rd < rounds; rd++)
            begin
                for (int lane = 0; lane < cc20_pkg::LANES; lane++)
                begin
                    ia = lane;
                    if ((rd % 2) == 0)
                    begin
                        ib = 4 + lane;
                        ic = 8 + lane;
                        id = 12 + lane;
                    end
                    else
                    begin
                        ib = 4 + (lane + 1) % 4;
                        ic = 8 + (lane + 2) % 4;
                        id = 12 + (lane + 3) % 4;
                    end
                    q = '{a: mix_w[ia], b: mix_w[ib], c: mix_w[ic], d: mix_w[id]};
                    q = quarter_round(q);
                    mix_w[ia] = q.a;
                    mix_w[ib] = q.b;
                    mix_w[ic] = q.c;
                    mix_w[id] = q.d;
                end
            end
            for (int i = 0; i < cc20_pkg::WORDS; i++)
            begin
                kw.word_index     = cc20_pkg::idx_t'(i);
                kw.mixed_word     = mix_w[i];
                kw.keystream_word = mix_w[i] + init_w[i];
                kw.last_word      = (cc20_pkg::idx_t'(i) == cc20_pkg::LAST_WORD_IDX);
                expected_words.push_back(kw);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_word(key_word_t got);
            key_word_t want;

            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word, index %0d", got.word_index));
                return;
            end
            want = expected_words.pop_front();
            if (got.word_index !== want.word_index)
                report_mismatch($sformatf("word_index got %0d want %0d",
                                          got.word_index, want.word_index));
            if (got.keystream_word !== want.keystream_word)
                report_mismatch($sformatf("word %0d keystream_word got %08h want %08h",
                                          want.word_index, got.keystream_word,
                                          want.keystream_word));
            if (got.mixed_word !== want.mixed_word)
                report_mismatch($sformatf("word %0d mixed_word got %08h want %08h",
                                          want.word_index, got.mixed_word,
                                          want.mixed_word));
            if (got.last_word !== want.last_word)
                report_mismatch($sformatf("word %0d last_word got %b want %b",
                                          want.word_index, got.last_word,
                                          want.last_word));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   blocks_accepted = 0;

    keystream_scoreboard sb;

    cc20_in_if  in_ch();
    cc20_out_if out_ch();

    chacha20_block_function #(
        .ROUND_COUNT(ROUNDS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .block_in (in_ch),
        .word_out (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic state_fields_t pack_words(cc20_pkg::word_t w[cc20_pkg::WORDS]);
        state_fields_t st;

        for (int i = 0; i < cc20_pkg::WORDS / 2; i++)
            st[i] = {w[2*i+1], w[2*i]};
        return st;
    endfunction

    function automatic void set_constants(ref cc20_pkg::word_t w[cc20_pkg::WORDS]);
        w[0] = 32'h61707865;
        w[1] = 32'h3320646e;
        w[2] = 32'h79622d32;
        w[3] = 32'h6b206574;
    endfunction

    function automatic state_fields_t directed_block(int d);
        cc20_pkg::word_t w[cc20_pkg::WORDS];

        for (int i = 0; i < cc20_pkg::WORDS; i++)
            w[i] = '0;
        case (d)
            0: ;
            1: for (int i = 0; i < cc20_pkg::WORDS; i++) w[i] = '1;
            2:
            begin
                set_constants(w);
                for (int i = 4; i < 12; i++)
                    w[i] = {8'(4*(i-4)+3), 8'(4*(i-4)+2), 8'(4*(i-4)+1), 8'(4*(i-4))};
                w[12] = 32'h00000001;
                w[13] = 32'h09000000;
                w[14] = 32'h4a000000;
                w[15] = 32'h00000000;
            end
            3: for (int i = 0; i < cc20_pkg::WORDS; i++) w[i] = 32'h55555555;
            4: for (int i = 0; i < cc20_pkg::WORDS; i++) w[i] = 32'haaaaaaaa;
            5: set_constants(w);
            6:
            begin
                for (int i = 0; i < cc20_pkg::WORDS; i++) w[i] = '1;
                set_constants(w);
            end
            15: for (int i = 0; i < cc20_pkg::WORDS; i++) w[i] = (i % 2) ? '1 : '0;
            16:
            begin
                for (int i = 0; i < cc20_pkg::WORDS; i++)
                    w[i] = cc20_pkg::word_t'(i) * 32'h11111111;
            end
            17:
            begin
                set_constants(w);
                w[12] = '1;
                w[13] = 32'hdeadbeef;
            end
            default:
            begin
                w[2*(d-7)]   = 32'h80000001;
                w[2*(d-7)+1] = 32'h00010000;
            end
        endcase
        return pack_words(w);
    endfunction

    function automatic cc20_pkg::word_t random_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom & $urandom & $urandom;
            3: return $urandom | $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic state_fields_t random_block();
        cc20_pkg::word_t w[cc20_pkg::WORDS];
        int              kind;

        kind = $urandom_range(0, 19);
        for (int i = 0; i < cc20_pkg::WORDS; i++)
            w[i] = (kind < 5) ? random_word() : cc20_pkg::word_t'($urandom);
        if (kind >= 5)
            set_constants(w);
        if (kind >= 17)
            w[12] = 32'hffffffff - cc20_pkg::word_t'($urandom_range(0, 3));
        return pack_words(w);
    endfunction

    task automatic drive_fields(state_fields_t st);
        in_ch.state_words_0_1   = st[0];
        in_ch.state_words_2_3   = st[1];
        in_ch.state_words_4_5   = st[2];
        in_ch.state_words_6_7   = st[3];
        in_ch.state_words_8_9   = st[4];
        in_ch.state_words_10_11 = st[5];
        in_ch.state_words_12_13 = st[6];
        in_ch.state_words_14_15 = st[7];
    endtask

    task automatic offer_block(state_fields_t st);
        @(negedge clk);
        drive_fields(st);
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_block(st);
        blocks_accepted++;
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            drive_fields({$urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom});
        end
    endtask

    function automatic int pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7: return $urandom_range(1, 20);
            8: return $urandom_range(21, 90);
            default: return $urandom_range(91, 150);
        endcase
    endfunction

    initial
    begin
        int sent;
        int burst;

        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        drive_fields('0);
        sb = new(ROUNDS);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int d = 0; d < DIRECTED_ITEMS; d++)
        begin
            offer_block(directed_block(d));
            if ($urandom_range(0, 2) == 0)
                idle_cycles(pick_gap() + 1);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 6);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++)
            begin
                offer_block(random_block());
                sent++;
            end
            idle_cycles(pick_gap() + 1);
        end

        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (4 * ROUNDS + 40) @(posedge clk);

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rx_mode_t mode;
        int       len;
        bit       held_off;

        out_ch.ready = 1'b0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            len = (mode == RX_SHUT) ? $urandom_range(1, 15) : $urandom_range(10, 80);
            if (!held_off && blocks_accepted >= HOLD_AFTER_BLOCKS)
            begin
                held_off = 1'b1;
                mode = RX_HOLD;
                len = HOLD_CYCLES;
            end
            repeat (len)
            begin
                @(negedge clk);
                case (mode)
                    RX_OPEN:   out_ch.ready = 1'b1;
                    RX_HALF:   out_ch.ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ch.ready = ($urandom_range(0, 3) == 0);
                    default:   out_ch.ready = 1'b0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_word('{word_index:     out_ch.word_index,
                            keystream_word: out_ch.keystream_word,
                            mixed_word:     out_ch.mixed_word,
                            last_word:      out_ch.last_word});
    end

    initial
    begin
        int cycles;

        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
